/* src/scsa_pkg.sv */
// Shared types, status codes and size-class tables for the slot allocator.
// Used by scsa_map_ram, scsa_op_unit and size_class_slot_allocator.
package scsa_pkg;

    localparam int MAP_W  = 58;
    localparam int ADDR_W = 32;
    localparam int TID_W  = 5;

    typedef logic [MAP_W-1:0]  t_map;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [2:0]        t_status;
    typedef logic [1:0]        t_func;

    localparam t_func FN_ALLOC   = 2'd0;
    localparam t_func FN_FREE    = 2'd1;
    localparam t_func FN_RECLAIM = 2'd2;

    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_ZERO     = 3'd1;
    localparam t_status ST_LARGE    = 3'd2;
    localparam t_status ST_FULL     = 3'd3;
    localparam t_status ST_RANGE    = 3'd4;
    localparam t_status ST_ALIGN    = 3'd5;
    localparam t_status ST_NOTALLOC = 3'd6;

    localparam logic [31:0] PAGE_BYTES = 32'h0000_1000;
    localparam logic [31:0] MAX_BLOCK  = 32'd512;

    // per class: first map bit, log2 slot size, region offset in page
    localparam logic [5:0]  CLS_FIRST  [4] = '{6'd0, 6'd32, 6'd48, 6'd56};
    localparam logic [3:0]  CLS_SHIFT  [4] = '{4'd5, 4'd6, 4'd7, 4'd9};
    localparam logic [11:0] CLS_OFFSET [4] = '{12'h000, 12'h400, 12'h800, 12'hC00};

    typedef struct packed {
        t_func             func;
        logic [TID_W-1:0]  tid;
        logic [31:0]       size;
        t_addr             ptr;
        logic              tid_ok;
    } t_req;

    typedef struct packed {
        t_status status;
        t_addr   addr;
        logic    wr_en;
        t_map    wr_map;
    } t_op_res;

endpackage

/* src/size_class_slot_allocator.sv */
// Per-thread size-class slot allocator, top level.
// Instantiates scsa_map_ram and scsa_op_unit; uses scsa_pkg.
//
// Usage:
//  Input stream (s_axis): tuser carries func (0 allocate, 1 free, 2 reclaim),
//  tdata carries thread_id, request_size and block_address. Each item gives
//  exactly one result on the output stream (m_axis): status and the granted
//  address (zero unless an allocate succeeds).
//  heap_base is written through i_cfg_we / i_cfg_wdata while the block is idle.
//  Flow: the item is accepted and its thread's slot map read from memory in
//  the same cycle; the modify step then changes the word, writes it back and
//  loads the output register once that register is free. The slot-map
//  read-modify-write takes no new item until the current one is written back.
//  A stalled receiver holds the result in the output register; the block
//  still accepts one more item and parks it in the modify step until the
//  output register frees up.
//  Reset clears heap_base, the control state and every entry's valid bit, so
//  all slots read as free; no clearing pass is needed.
module size_class_slot_allocator #(
    parameter int THREAD_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,  // [4:0] thread_id, [36:5] request_size,
                                         // [68:37] block_address, [71:69] zero
    input  logic [1:0]  i_s_axis_tuser,  // [1:0] func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata   // [2:0] status, [34:3] granted_address,
                                         // [39:35] zero
);
    import scsa_pkg::*;

    localparam int AW = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;

    logic     r_busy;
    logic     r_out_vld;
    t_req     r_req;
    t_addr    r_heap_base;
    t_status  r_out_status;
    t_addr    r_out_addr;
    t_req     in_req;
    t_map     rd_map;
    t_op_res  res;
    logic     accept;
    logic     done;

    assign in_req.func   = i_s_axis_tuser;
    assign in_req.tid    = i_s_axis_tdata[4:0];
    assign in_req.size   = i_s_axis_tdata[36:5];
    assign in_req.ptr    = i_s_axis_tdata[68:37];
    assign in_req.tid_ok = 32'(i_s_axis_tdata[4:0]) < 32'(THREAD_COUNT);

    assign o_s_axis_tready = !r_busy;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign done            = r_busy && (!r_out_vld || i_m_axis_tready);

    scsa_map_ram #(
        .DEPTH (THREAD_COUNT),
        .AW    (AW)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (AW'(in_req.tid)),
        .o_rd_data (rd_map),
        .i_wr_en   (done && res.wr_en),
        .i_wr_addr (AW'(r_req.tid)),
        .i_wr_data (res.wr_map)
    );

    scsa_op_unit u_op_unit (
        .i_req       (r_req),
        .i_map       (rd_map),
        .i_heap_base (r_heap_base),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_vld   <= 1'b0;
            r_heap_base <= '0;
        end else begin
            if (i_cfg_we) begin
                r_heap_base <= i_cfg_wdata;
            end
            if (accept) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (done) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= in_req;
        end
        if (done) begin
            r_out_status <= res.status;
            r_out_addr   <= res.addr;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {5'b0, r_out_addr, r_out_status};

`ifndef SYNTH
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_axis_tready)
        else $error("item accepted while another is in the modify step");

    a_done_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> o_m_axis_tvalid)
        else $error("completed item did not reach the output register");

    a_addr_zero_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_out_status != ST_OK) |-> r_out_addr == '0)
        else $error("nonzero granted address on a failed item");

    a_write_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.wr_en && done) |-> r_busy && !accept)
        else $error("slot-map write outside the modify step");
`endif

endmodule

/* src/scsa_map_ram.sv */
// Slot-map memory: one 58-bit word per thread, registered read.
// Per-entry valid bits make never-written entries read as all free. Uses scsa_pkg.
module scsa_map_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output scsa_pkg::t_map    o_rd_data,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  scsa_pkg::t_map    i_wr_data
);
    import scsa_pkg::*;

    t_map             mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    t_map             r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

/* src/scsa_op_unit.sv */
// Modify step: decodes one item against the thread's slot map and forms
// the status, granted address and write-back word. Uses scsa_pkg.
module scsa_op_unit (
    input  scsa_pkg::t_req    i_req,
    input  scsa_pkg::t_map    i_map,
    input  scsa_pkg::t_addr   i_heap_base,
    output scsa_pkg::t_op_res o_res
);
    import scsa_pkg::*;

    t_addr       page_base;
    logic [1:0]  a_cls;
    logic [31:0] used;
    logic        a_found;
    logic [4:0]  a_idx;
    logic [5:0]  a_pos;
    t_addr       a_addr;
    t_addr       f_off;
    logic [1:0]  f_cls;
    logic [11:0] f_mask;
    logic [5:0]  f_slot;
    logic [5:0]  f_pos;

    assign page_base = i_heap_base + 32'({i_req.tid, 12'h000});

    // allocate: class from size, lowest free slot in that class
    always_comb begin
        if (i_req.size <= 32'd32) begin
            a_cls = 2'd0;
        end else if (i_req.size <= 32'd64) begin
            a_cls = 2'd1;
        end else if (i_req.size <= 32'd128) begin
            a_cls = 2'd2;
        end else begin
            a_cls = 2'd3;
        end
        case (a_cls)
            2'd0:    used = i_map[31:0];
            2'd1:    used = {16'hFFFF, i_map[47:32]};
            2'd2:    used = {24'hFF_FFFF, i_map[55:48]};
            default: used = {30'h3FFF_FFFF, i_map[57:56]};
        endcase
        a_found = 1'b0;
        a_idx   = '0;
        for (int i = 0; i < 32; i++) begin
            if (!used[i] && !a_found) begin
                a_found = 1'b1;
                a_idx   = 5'(i);
            end
        end
        a_pos  = CLS_FIRST[a_cls] + {1'b0, a_idx};
        a_addr = page_base + 32'(CLS_OFFSET[a_cls]) + (32'(a_idx) << CLS_SHIFT[a_cls]);
    end

    // free: offset within page, region decode, slot bit
    always_comb begin
        f_off  = i_req.ptr - page_base;
        f_cls  = f_off[11:10];
        f_mask = 12'((13'd1 << CLS_SHIFT[f_cls]) - 13'd1);
        f_slot = 6'(f_off[9:0] >> CLS_SHIFT[f_cls]);
        f_pos  = CLS_FIRST[f_cls] + f_slot;
    end

    always_comb begin
        o_res.status = ST_OK;
        o_res.addr   = '0;
        o_res.wr_en  = 1'b0;
        o_res.wr_map = i_map;
        case (i_req.func)
            FN_ALLOC: begin
                if (!i_req.tid_ok) begin
                    o_res.status = ST_RANGE;
                end else if (i_req.size == '0) begin
                    o_res.status = ST_ZERO;
                end else if (i_req.size > MAX_BLOCK) begin
                    o_res.status = ST_LARGE;
                end else if (!a_found) begin
                    o_res.status = ST_FULL;
                end else begin
                    o_res.addr   = a_addr;
                    o_res.wr_en  = 1'b1;
                    o_res.wr_map = i_map | (t_map'(1) << a_pos);
                end
            end
            FN_FREE: begin
                if (!i_req.tid_ok || f_off >= PAGE_BYTES) begin
                    o_res.status = ST_RANGE;
                end else if ((f_off[11:0] & f_mask) != '0) begin
                    o_res.status = ST_ALIGN;
                end else if (!i_map[f_pos]) begin
                    o_res.status = ST_NOTALLOC;
                end else begin
                    o_res.wr_en  = 1'b1;
                    o_res.wr_map = i_map & ~(t_map'(1) << f_pos);
                end
            end
            FN_RECLAIM: begin
                if (i_req.tid_ok) begin
                    o_res.wr_en  = 1'b1;
                    o_res.wr_map = '0;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
